// ===== hdl/slu_pkg.sv =====
// Shared types and character constants for the string literal unescape block.
`default_nettype none
package slu_pkg;

	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_APOS   = 8'h27;
	localparam logic [7:0] CHR_QMARK  = 8'h3F;
	localparam logic [7:0] CHR_A      = 8'h61;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] CHR_N      = 8'h6E;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_V      = 8'h76;
	localparam logic [7:0] CHR_X      = 8'h78;
	localparam logic [7:0] CHR_0      = 8'h30;
	localparam logic [7:0] CHR_3      = 8'h33;
	localparam logic [7:0] CHR_7      = 8'h37;
	localparam logic [7:0] CHR_9      = 8'h39;
	localparam logic [7:0] CHR_LC_A   = 8'h61;
	localparam logic [7:0] CHR_LC_F   = 8'h66;
	localparam logic [7:0] CHR_UC_A   = 8'h41;
	localparam logic [7:0] CHR_UC_F   = 8'h46;

	localparam logic [7:0] CTL_BEL = 8'h07;
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_HT  = 8'h09;
	localparam logic [7:0] CTL_VT  = 8'h0B;

	// positions after the lead character of a numeric escape
	localparam logic [1:0] SPAN_TAIL = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       simple_hit;
		logic [7:0] simple_char;
		logic       backslash;
		logic       oct_start;
		logic       hex_start;
		logic       oct_digit;
		logic       hex_digit;
		logic [3:0] digit;
	} byte_class_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       end_of_literal;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/string_literal_unescape_top.sv =====
// Top level of the string literal unescape block.
//
// Bytes of one quoted literal token go in on the push/full channel, one word
// per byte, with last_byte set on the closing quote. Every byte gives exactly
// one result word on the empty/pop channel: char_valid with out_char when a
// character is decoded, end_of_literal on the word caused by the closing byte.
// The opening and closing quotes give no character; escapes are decoded.
//
// Throughput: one byte per cycle in both directions while the receiver pops.
// A pushed byte is classified into a two-word queue, then decoded into a
// two-word result queue once that has room, and from there shows on the
// result ports (empty low).
// When the receiver stalls, the result queue fills, the decoder holds, and
// the byte queue fills; full rises once both are full. Nothing is dropped.
// Reset empties both queues and returns the decoder to wait for an opening
// quote.
`default_nettype none
module string_literal_unescape_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       pop,
	output logic            empty,
	output logic            char_valid,
	output logic [7:0]      out_char,
	output logic            end_of_literal
);
	import slu_pkg::*;

	byte_class_t cls_in;
	byte_class_t cls_out;
	logic        cls_empty;
	logic        cls_pop;
	result_t     res;

	slu_front u_front (
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cls       (cls_in)
	);

	slu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_word (cls_in),
		.full    (full),
		.pop     (cls_pop),
		.rd_word (cls_out),
		.empty   (cls_empty)
	);

	slu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_out),
		.cls_empty (cls_empty),
		.cls_pop   (cls_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign char_valid     = res.char_valid;
	assign out_char       = res.out_char;
	assign end_of_literal = res.end_of_literal;

endmodule
`default_nettype wire

// ===== hdl/slu_front.sv =====
// Front end: classifies each raw byte for the decoder.
`default_nettype none
module slu_front (
	input  wire logic [7:0]          data_byte,
	input  wire logic                last_byte,
	output slu_pkg::byte_class_t     cls
);
	import slu_pkg::*;

	always_comb begin
		cls = '0;
		cls.data = data_byte;
		cls.last = last_byte;
		cls.simple_hit = 1'b1;
		case (data_byte)
			CHR_APOS:   cls.simple_char = CHR_APOS;
			CHR_QUOTE:  cls.simple_char = CHR_QUOTE;
			CHR_QMARK:  cls.simple_char = CHR_QMARK;
			CHR_BSLASH: cls.simple_char = CHR_BSLASH;
			CHR_A:      cls.simple_char = CTL_BEL;
			CHR_B:      cls.simple_char = CTL_BS;
			CHR_F:      cls.simple_char = CTL_FF;
			CHR_N:      cls.simple_char = CTL_LF;
			CHR_R:      cls.simple_char = CTL_CR;
			CHR_T:      cls.simple_char = CTL_HT;
			CHR_V:      cls.simple_char = CTL_VT;
			default: begin
				cls.simple_hit  = 1'b0;
				cls.simple_char = 8'h00;
			end
		endcase
		cls.backslash = (data_byte == CHR_BSLASH);
		cls.hex_start = (data_byte == CHR_X);
		cls.oct_start = (data_byte inside {[CHR_0:CHR_3]});
		cls.oct_digit = (data_byte inside {[CHR_0:CHR_7]});
		if (data_byte inside {[CHR_0:CHR_9]}) begin
			cls.hex_digit = 1'b1;
			cls.digit     = data_byte[3:0];
		end else if (data_byte inside {[CHR_LC_A:CHR_LC_F], [CHR_UC_A:CHR_UC_F]}) begin
			// letters: low nibble 1..6 maps to 10..15
			cls.hex_digit = 1'b1;
			cls.digit     = data_byte[3:0] + 4'd9;
		end else begin
			cls.hex_digit = 1'b0;
			cls.digit     = 4'd0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/slu_queue.sv =====
// Two-entry queue of classified bytes between front and back.
`default_nettype none
module slu_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire slu_pkg::byte_class_t wr_word,
	output logic                      full,
	input  wire logic                 pop,
	output slu_pkg::byte_class_t      rd_word,
	output logic                      empty
);
	import slu_pkg::*;

	byte_class_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

// ===== hdl/slu_back.sv =====
// Back end: escape state machine and two-entry result queue.
`default_nettype none
module slu_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire slu_pkg::byte_class_t cls,
	input  wire logic                 cls_empty,
	output logic                      cls_pop,
	input  wire logic                 pop,
	output logic                      empty,
	output slu_pkg::result_t          res
);
	import slu_pkg::*;

	typedef enum logic [2:0] {
		MODE_OPEN  = 3'd0,
		MODE_PLAIN = 3'd1,
		MODE_ESC   = 3'd2,
		MODE_OCT   = 3'd3,
		MODE_HEX   = 3'd4
	} mode_t;

	mode_t      mode_q, mode_d;
	logic [1:0] left_q, left_d, left_dec;
	logic [7:0] value_q, value_d;
	logic       stop_q, stop_d;
	result_t    res_d;

	result_t    out_mem_q [2];
	logic       out_wr_q;
	logic       out_rd_q;
	logic [1:0] out_cnt_q;
	logic       out_full;
	logic       take;
	logic       give;
	logic       is_digit;
	logic [7:0] grown;

	assign out_full = (out_cnt_q == 2'd2);
	assign empty    = (out_cnt_q == 2'd0);
	assign take     = !cls_empty && !out_full;
	assign give     = pop && !empty;
	assign cls_pop  = take;
	assign res      = out_mem_q[out_rd_q];
	assign left_dec = left_q - 2'd1;

	always_comb begin
		is_digit = (mode_q == MODE_OCT) ? cls.oct_digit : cls.hex_digit;
		grown    = (mode_q == MODE_OCT) ? {value_q[4:0], cls.digit[2:0]}
		                                : {value_q[3:0], cls.digit};
		mode_d  = mode_q;
		left_d  = left_q;
		value_d = value_q;
		stop_d  = stop_q;
		res_d   = '0;
		res_d.end_of_literal = cls.last;
		if (cls.last) begin
			if (mode_q == MODE_OCT || mode_q == MODE_HEX) begin
				res_d.char_valid = 1'b1;
				res_d.out_char   = value_q;
			end
			mode_d  = MODE_OPEN;
			left_d  = 2'd0;
			value_d = 8'd0;
			stop_d  = 1'b0;
		end else begin
			case (mode_q)
				MODE_OPEN: begin
					mode_d = MODE_PLAIN;
				end
				MODE_ESC: begin
					if (cls.simple_hit) begin
						res_d.char_valid = 1'b1;
						res_d.out_char   = cls.simple_char;
						mode_d           = MODE_PLAIN;
					end else if (cls.oct_start) begin
						value_d = {6'd0, cls.digit[1:0]};
						left_d  = SPAN_TAIL;
						stop_d  = 1'b0;
						mode_d  = MODE_OCT;
					end else if (cls.hex_start) begin
						value_d = 8'd0;
						left_d  = SPAN_TAIL;
						stop_d  = 1'b0;
						mode_d  = MODE_HEX;
					end else begin
						// unknown escape: drop the backslash, keep the byte
						res_d.char_valid = 1'b1;
						res_d.out_char   = cls.data;
						mode_d           = MODE_PLAIN;
					end
				end
				MODE_OCT, MODE_HEX: begin
					if (!stop_q && is_digit) begin
						value_d = grown;
					end else begin
						stop_d = 1'b1;
					end
					left_d = left_dec;
					if (left_dec == 2'd0) begin
						res_d.char_valid = 1'b1;
						res_d.out_char   = (!stop_q && is_digit) ? grown : value_q;
						mode_d           = MODE_PLAIN;
						value_d          = 8'd0;
						stop_d           = 1'b0;
					end
				end
				default: begin
					if (cls.backslash) begin
						mode_d = MODE_ESC;
					end else begin
						res_d.char_valid = 1'b1;
						res_d.out_char   = cls.data;
						mode_d           = MODE_PLAIN;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_mem_q[out_wr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OPEN;
			left_q    <= 2'd0;
			value_q   <= 8'd0;
			stop_q    <= 1'b0;
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (take) begin
				mode_q   <= mode_d;
				left_q   <= left_d;
				value_q  <= value_d;
				stop_q   <= stop_d;
				out_wr_q <= !out_wr_q;
			end
			if (give) begin
				out_rd_q <= !out_rd_q;
			end
			out_cnt_q <= out_cnt_q + {1'b0, take} - {1'b0, give};
		end
	end

endmodule
`default_nettype wire

// ===== dv/string_literal_unescape_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for string_literal_unescape_top: directed and random literal tokens.
module string_literal_unescape_top_test;
	import slu_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int BYTE_TARGET  = 1100;
	localparam int MAX_GAP      = 18;
	localparam int LONG_HOLD    = 90;
	localparam int HOLD_AT_WORD = 400;
	localparam int PAUSE_AT     = 550;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int SETTLE       = 8;
	localparam int REPORT_LIMIT = 10;

	localparam logic [7:0] SIMPLE_SET [11] = '{CHR_APOS, CHR_QUOTE, CHR_QMARK, CHR_BSLASH,
		CHR_A, CHR_B, CHR_F, CHR_N, CHR_R, CHR_T, CHR_V};

	typedef enum logic [2:0] {
		MODE_OPEN, MODE_BODY, MODE_ESCAPE, MODE_OCTAL, MODE_HEX
	} decode_mode_e;

	class unescape_board;
		decode_mode_e mode;
		logic [1:0]   span_left;
		logic [7:0]   acc;
		bit           halted;
		result_t      expected_words[$];
		int unsigned  faults;

		function new();
			faults = 0;
			clear_state();
		endfunction

		function void clear_state();
			mode      = MODE_OPEN;
			span_left = '0;
			acc       = '0;
			halted    = 1'b0;
		endfunction

		function int simple_char(logic [7:0] b);
			case (b)
			CHR_APOS, CHR_QUOTE, CHR_QMARK, CHR_BSLASH: return int'(b);
			CHR_A: return int'(CTL_BEL);
			CHR_B: return int'(CTL_BS);
			CHR_F: return int'(CTL_FF);
			CHR_N: return int'(CTL_LF);
			CHR_R: return int'(CTL_CR);
			CHR_T: return int'(CTL_HT);
			CHR_V: return int'(CTL_VT);
			default: return -1;
			endcase
		endfunction

		function int digit_value(logic [7:0] b, bit hex);
			if (b >= CHR_0 && b <= CHR_7) return int'(b - CHR_0);
			if (!hex) return -1;
			if (b > CHR_7 && b <= CHR_9) return int'(b - CHR_0);
			if (b >= CHR_LC_A && b <= CHR_LC_F) return int'(b - CHR_LC_A) + 10;
			if (b >= CHR_UC_A && b <= CHR_UC_F) return int'(b - CHR_UC_A) + 10;
			return -1;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		function void fault(string msg);
			faults++;
			if (faults <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			result_t w;
			int      m;
			int      d;
			w = '0;
			w.end_of_literal = fin;
			if (fin) begin
				// flush a numeric escape still in progress with the end word
				if (mode == MODE_OCTAL || mode == MODE_HEX) begin
					w.char_valid = 1'b1;
					w.out_char   = acc;
				end
				clear_state();
			end else begin
				case (mode)
				MODE_OPEN: mode = MODE_BODY;
				MODE_ESCAPE: begin
					m = simple_char(b);
					if (m >= 0) begin
						w.char_valid = 1'b1;
						w.out_char   = m[7:0];
						mode         = MODE_BODY;
					end else if (b >= CHR_0 && b <= CHR_3) begin
						acc       = b - CHR_0;
						span_left = SPAN_TAIL;
						halted    = 1'b0;
						mode      = MODE_OCTAL;
					end else if (b == CHR_X) begin
						acc       = '0;
						span_left = SPAN_TAIL;
						halted    = 1'b0;
						mode      = MODE_HEX;
					end else begin
						w.char_valid = 1'b1;
						w.out_char   = b;
						mode         = MODE_BODY;
					end
				end
				MODE_OCTAL, MODE_HEX: begin
					d = digit_value(b, mode == MODE_HEX);
					if (!halted && d >= 0)
						acc = (mode == MODE_HEX) ? {acc[3:0], d[3:0]} : {acc[4:0], d[2:0]};
					else
						halted = 1'b1;
					span_left = span_left - 2'd1;
					if (span_left == 2'd0) begin
						w.char_valid = 1'b1;
						w.out_char   = acc;
						mode         = MODE_BODY;
						acc          = '0;
						halted       = 1'b0;
					end
				end
				default: begin
					if (b == CHR_BSLASH) begin
						mode = MODE_ESCAPE;
					end else begin
						w.char_valid = 1'b1;
						w.out_char   = b;
						mode         = MODE_BODY;
					end
				end
				endcase
			end
			expected_words.push_back(w);
		endfunction

		function void check_word(logic cv, logic [7:0] ch, logic eol);
			result_t w;
			if (expected_words.size() == 0) begin
				fault($sformatf("unexpected word: char_valid=%0b out_char=%02h end_of_literal=%0b",
					cv, ch, eol));
				return;
			end
			w = expected_words.pop_front();
			if (w.char_valid !== cv || w.out_char !== ch || w.end_of_literal !== eol)
				fault($sformatf("word mismatch: expected %0b/%02h/%0b, got %0b/%02h/%0b",
					w.char_valid, w.out_char, w.end_of_literal, cv, ch, eol));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic        char_valid;
	logic [7:0]  out_char;
	logic        end_of_literal;
	bit          no_idle = 1'b0;
	bit          flood = 1'b0;
	int unsigned bytes_sent = 0;
	int unsigned words_seen = 0;
	logic [7:0]  token_bytes[$];
	unescape_board board = new();

	string_literal_unescape_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.pop            (pop),
		.empty          (empty),
		.char_valid     (char_valid),
		.out_char       (out_char),
		.end_of_literal (end_of_literal)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// one position of a numeric span: mostly a digit of the base, sometimes any byte
	function automatic logic [7:0] span_byte(bit hex);
		int v;
		if ($urandom_range(0, 3) == 0) return 8'($urandom);
		if (!hex) return CHR_0 + 8'($urandom_range(0, 7));
		v = $urandom_range(0, 21);
		if (v < 10) return CHR_0 + 8'(v);
		if (v < 16) return CHR_LC_A + 8'(v - 10);
		return CHR_UC_A + 8'(v - 16);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = flood ? 0 : draw_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_token();
		foreach (token_bytes[i]) send_byte(token_bytes[i], i == token_bytes.size() - 1);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// receiver
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && words_seen >= HOLD_AT_WORD) begin
				// hold off so both queues fill and full rises; the sender floods meanwhile
				held  = 1'b1;
				flood = 1'b1;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				flood = 1'b0;
				gap   = 0;
			end else begin
				gap = draw_gap();
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			board.check_word(char_valid, out_char, end_of_literal);
			words_seen++;
		end
	end

	// sender and end of run
	initial begin
		int n;
		int k;
		bit cut;
		bit paused;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte token, then a body with extremes and every kind of escape
		token_bytes = '{CHR_QUOTE};
		send_token();
		token_bytes = '{CHR_QUOTE, 8'h00, 8'hFF, CHR_BSLASH, CHR_N, CHR_BSLASH, CHR_3, CHR_7,
			CHR_7, CHR_BSLASH, 8'h71, CHR_BSLASH, CHR_BSLASH, CHR_BSLASH, CHR_X, CHR_LC_F,
			CHR_QUOTE};
		send_token();
		// backslash right before the closing byte
		token_bytes = '{CHR_QUOTE, CHR_BSLASH, 8'h80};
		send_token();
		// hex escape with no digit; the later digit in the span is dropped
		token_bytes = '{CHR_QUOTE, CHR_BSLASH, CHR_X, 8'h5A, CHR_9, CHR_QUOTE};
		send_token();
		wait_drained();

		while (bytes_sent < BYTE_TARGET) begin
			if ($urandom_range(0, 9) == 0) no_idle = ~no_idle;
			if (!paused && bytes_sent >= PAUSE_AT) begin
				paused = 1'b1;
				wait_drained();
			end
			if ($urandom_range(0, 5) == 0) begin
				// raw noise, usually closed by a flagged byte to resync the decoder
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom), (i == n - 1) ? ($urandom_range(0, 3) != 0)
						: ($urandom_range(0, 7) == 0));
			end else begin
				token_bytes.delete();
				token_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : CHR_QUOTE);
				n   = $urandom_range(0, 10);
				cut = 1'b0;
				for (int i = 0; i < n && !cut; i++) begin
					k = $urandom_range(0, 19);
					if (k < 7) begin
						token_bytes.push_back(8'($urandom));
					end else if (k < 11) begin
						token_bytes.push_back(CHR_BSLASH);
						token_bytes.push_back(SIMPLE_SET[$urandom_range(0, 10)]);
					end else if (k < 14) begin
						token_bytes.push_back(CHR_BSLASH);
						token_bytes.push_back(CHR_0 + 8'($urandom_range(0, 3)));
						token_bytes.push_back(span_byte(1'b0));
						token_bytes.push_back(span_byte(1'b0));
					end else if (k < 17) begin
						token_bytes.push_back(CHR_BSLASH);
						token_bytes.push_back(CHR_X);
						token_bytes.push_back(span_byte(1'b1));
						token_bytes.push_back(span_byte(1'b1));
					end else if (k < 19) begin
						token_bytes.push_back(CHR_BSLASH);
						token_bytes.push_back(8'($urandom));
					end else begin
						// cut the token short inside an escape
						token_bytes.push_back(CHR_BSLASH);
						case ($urandom_range(0, 2))
						0: ;
						1: begin
							token_bytes.push_back(CHR_0 + 8'($urandom_range(0, 3)));
							if ($urandom_range(0, 1) == 1) token_bytes.push_back(span_byte(1'b0));
						end
						default: begin
							token_bytes.push_back(CHR_X);
							if ($urandom_range(0, 1) == 1) token_bytes.push_back(span_byte(1'b1));
						end
						endcase
						cut = 1'b1;
					end
				end
				token_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : CHR_QUOTE);
				send_token();
			end
		end

		push <= 1'b0;
		n = 0;
		while (board.outstanding() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
		if (board.outstanding() != 0)
			board.fault($sformatf("%0d expected words never arrived", board.outstanding()));
		if (board.faults == 0)
			$display("string_literal_unescape_top_test: PASS");
		else
			$display("string_literal_unescape_top_test: FAIL");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout: run did not complete");
		$display("string_literal_unescape_top_test: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/slu_pkg.sv
hdl/slu_front.sv
hdl/slu_queue.sv
hdl/slu_back.sv
hdl/string_literal_unescape_top.sv
dv/string_literal_unescape_top_test.sv
